>>> rtl/mps_pkg.sv
// Shared constants and types for the multi-strategy process scheduler.
// No dependencies.
package mps_pkg;

    localparam int NumSlotsDef = 8;
    localparam int AgeWidthDef = 16;
    localparam int SlotW       = 3;
    localparam int PrioW       = 8;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_READY = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // strategy codes
    localparam logic [1:0] STRAT_EVEN  = 2'd0;
    localparam logic [1:0] STRAT_RTC   = 2'd1;
    localparam logic [1:0] STRAT_RR    = 2'd2;
    localparam logic [1:0] STRAT_AGING = 2'd3;

    // control from sequencer into the cell chain
    typedef struct packed {
        logic       shift;      // rotate chain one place
        logic       age_step;   // head cell adds its priority to its age
        logic       write;      // head cell takes a command
        logic       start;      // command is start (else set ready)
        logic       rdy;        // new ready flag
        logic       clr_ages;   // clear all ages
        logic       win_load;   // head cell: age := priority
    } mps_ctrl_t;

endpackage

>>> rtl/mps_cell.sv
// One slot cell of the rotating slot table: ready flag, priority and age.
// Depends on mps_pkg.
module mps_cell #(
    parameter int AGE_WIDTH = mps_pkg::AgeWidthDef
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mps_pkg::mps_ctrl_t       ctrl,
    input  logic                     is_head,
    input  logic                     age_en,
    input  logic [mps_pkg::PrioW-1:0] prio_in,
    input  logic                     rdy_in,
    input  logic [AGE_WIDTH-1:0]     age_in,
    output logic                     rdy_out,
    output logic [mps_pkg::PrioW-1:0] prio_out,
    output logic [AGE_WIDTH-1:0]     age_out
);
    localparam logic [AGE_WIDTH-1:0] AgeMax = '1;

    logic                      rdy_reg, rdy_next;
    logic [mps_pkg::PrioW-1:0] prio_reg, prio_next;
    logic [AGE_WIDTH-1:0]      age_reg, age_next;
    logic [AGE_WIDTH:0]        sum;
    logic [AGE_WIDTH-1:0]      age_aged;

    // saturating age step
    assign sum = {1'b0, age_reg} + {{(AGE_WIDTH+1-mps_pkg::PrioW){1'b0}}, prio_reg};

    // the head steps its age on the way out, since it shifts in the same cycle
    assign age_aged = (is_head && ctrl.age_step && age_en && rdy_reg)
                    ? (sum[AGE_WIDTH] ? AgeMax : sum[AGE_WIDTH-1:0]) : age_reg;

    always_comb
    begin
        rdy_next  = rdy_reg;
        prio_next = prio_reg;
        age_next  = age_reg;
        if (is_head && ctrl.write)
        begin
            rdy_next = ctrl.rdy;
            if (ctrl.start)
            begin
                rdy_next  = 1'b1;
                prio_next = prio_in;
                age_next  = '0;
            end
        end
        if (is_head && ctrl.win_load)
            age_next = {{(AGE_WIDTH-mps_pkg::PrioW){1'b0}}, prio_reg};
        if (ctrl.clr_ages)
            age_next = '0;
        if (ctrl.shift)
        begin
            rdy_next  = rdy_in;
            prio_next = prio_in;
            age_next  = ctrl.clr_ages ? '0 : age_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdy_reg  <= 1'b0;
            prio_reg <= '0;
            age_reg  <= '0;
        end
        else
        begin
            rdy_reg  <= rdy_next;
            prio_reg <= prio_next;
            age_reg  <= age_next;
        end
    end

    assign rdy_out  = rdy_reg;
    assign prio_out = prio_reg;
    assign age_out  = age_aged;
endmodule

>>> rtl/multi_strategy_process_scheduler.sv
// Top level of the multi-strategy process scheduler: sequencer and cell ring.
// Depends on mps_pkg and mps_cell.
//
// The slot table is a ring of NUM_SLOTS cells that rotates one place per
// cycle while it shifts; the slot sitting in the head cell is tracked by a
// pointer. Every item is first accepted in the idle state. A start or
// set-ready command then rotates the wanted slot to the head and writes it.
// A schedule tick makes one full revolution of the ring and then a decision
// step; inactive aging with a ready slot, and round robin falling back to
// idle slot 0, then rotate the chosen slot to the head. The decision step
// stalls while an earlier result still waits in the output register. A
// strategy write selecting round robin then brings the current slot to the
// head and loads the time slice. One item is in flight at a time; the
// result sits in an output register while later items are taken.
module multi_strategy_process_scheduler #(
    parameter int NUM_SLOTS = mps_pkg::NumSlotsDef,
    parameter int AGE_WIDTH = mps_pkg::AgeWidthDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [2:0]  slot,
    input  logic        ready_req,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  next_process,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    localparam int IW = $clog2(NUM_SLOTS);
    localparam int PW = mps_pkg::PrioW;
    localparam logic [IW-1:0] LastIdx = IW'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {S_IDLE, S_CMD, S_SCAN, S_WIN, S_DONE} state_t;

    state_t              state_reg;
    logic [1:0]          strat_reg;
    logic [IW-1:0]       head_reg;     // slot currently in the head cell
    logic [IW-1:0]       cur_reg;
    logic [PW-1:0]       slice_reg;
    logic [1:0]          cmd_reg;
    logic [2:0]          slot_reg;
    logic                rdy_reg;
    logic [PW-1:0]       prio_reg;
    logic [IW:0]         cnt_reg;
    logic                out_valid_reg;
    logic [2:0]          out_reg;
    logic                cfg_pend_reg;  // strategy 2 write: load slice from head scan
    // scan results
    logic                ev_found_reg;
    logic [IW-1:0]       ev_best_reg;  // first ready slot other than 0 after cur in cyclic order
    logic [IW-1:0]       ev_dist_reg;
    logic [PW-1:0]       ev_prio_reg;
    logic                cur_rdy_reg;
    logic                ag_found_reg;
    logic [IW-1:0]       ag_best_reg;
    logic [AGE_WIDTH-1:0] ag_age_reg;
    logic [PW-1:0]       ag_prio_reg;

    mps_pkg::mps_ctrl_t  ctrl;
    logic [NUM_SLOTS-1:0]  c_rdy;
    logic [PW-1:0]         c_prio [NUM_SLOTS];
    logic [AGE_WIDTH-1:0]  c_age  [NUM_SLOTS];

    // ring of cells; cell 0 is the head, data moves from cell k+1 to k
    for (genvar k = 0; k < NUM_SLOTS; k++)
    begin : g_cell
        localparam int Nx = (k + 1) % NUM_SLOTS;
        mps_cell #(.AGE_WIDTH(AGE_WIDTH)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .is_head  (k == 0),
            .age_en   (head_reg != cur_reg),
            .prio_in  ((k == 0 && !ctrl.shift) ? prio_reg : c_prio[Nx]),
            .rdy_in   (c_rdy[Nx]),
            .age_in   (c_age[Nx]),
            .rdy_out  (c_rdy[k]),
            .prio_out (c_prio[k]),
            .age_out  (c_age[k])
        );
    end

    // head age as it will be after the aging step this cycle (stepped in the cell)
    logic [AGE_WIDTH-1:0] h_age;
    logic [IW-1:0]        h_next, cyc_dist;
    logic                 slot_ok;
    assign h_age = c_age[0];
    assign h_next = (head_reg == LastIdx) ? '0 : head_reg + 1'b1;
    // cyclic distance of head after cur over slots 1..N-1
    always_comb
    begin
        if (head_reg > cur_reg)
            cyc_dist = head_reg - cur_reg;
        else
            cyc_dist = IW'(head_reg + LastIdx - cur_reg);
    end
    assign slot_ok = ({{(32-3){1'b0}}, slot_reg} < NUM_SLOTS);

    // decision and result timing
    logic done_go, win_hit, to_win, res_set;
    assign done_go = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign win_hit = (state_reg == S_WIN) && (head_reg == ag_best_reg);
    assign to_win  = (strat_reg == mps_pkg::STRAT_RR && slice_reg == '0 && !ev_found_reg)
                  || (strat_reg == mps_pkg::STRAT_AGING && ag_found_reg);
    assign res_set = (done_go && !to_win) || win_hit;

    always_comb
    begin
        ctrl = '0;
        ctrl.rdy   = rdy_reg;
        ctrl.start = (cmd_reg == mps_pkg::CMD_START);
        ctrl.clr_ages = cfg_valid && cfg_ready && (cfg_data == mps_pkg::STRAT_AGING);
        unique case (state_reg)
            S_IDLE:
            begin
                // bring the current slot to the head for the slice load
                if (cfg_pend_reg && head_reg != cur_reg)
                    ctrl.shift = 1'b1;
            end
            S_CMD:
            begin
                if (!slot_ok)
                    ctrl.write = 1'b0;
                else if (head_reg == IW'(slot_reg))
                    ctrl.write = 1'b1;
                else
                    ctrl.shift = 1'b1;
            end
            S_SCAN:
            begin
                ctrl.shift    = 1'b1;
                ctrl.age_step = (strat_reg == mps_pkg::STRAT_AGING);
            end
            S_WIN:
            begin
                // age reload only under aging; round robin just reads the priority
                if (head_reg != ag_best_reg)
                    ctrl.shift = 1'b1;
                else
                    ctrl.win_load = (strat_reg == mps_pkg::STRAT_AGING);
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) && !cfg_pend_reg && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) && !cfg_pend_reg;
    assign out_valid = out_valid_reg;
    assign next_process = out_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            strat_reg     <= mps_pkg::STRAT_EVEN;
            head_reg      <= '0;
            cur_reg       <= '0;
            slice_reg     <= '0;
            out_valid_reg <= 1'b0;
            cfg_pend_reg  <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= res_set || (out_valid_reg && !out_ready);
            if (ctrl.shift)
                head_reg <= h_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_pend_reg)
                    begin
                        // slice load waits until cur slot is at head
                        if (head_reg == cur_reg)
                        begin
                            slice_reg    <= c_prio[0];
                            cfg_pend_reg <= 1'b0;
                        end
                    end
                    else if (cfg_valid)
                    begin
                        strat_reg <= cfg_data;
                        if (cfg_data == mps_pkg::STRAT_RR)
                            cfg_pend_reg <= 1'b1;
                    end
                    else if (in_valid)
                    begin
                        cmd_reg  <= cmd;
                        slot_reg <= slot;
                        rdy_reg  <= ready_req;
                        prio_reg <= priority_req;
                        if (cmd == mps_pkg::CMD_START || cmd == mps_pkg::CMD_READY)
                            state_reg <= S_CMD;
                        else if (cmd == mps_pkg::CMD_TICK)
                        begin
                            state_reg    <= S_SCAN;
                            cnt_reg      <= '0;
                            ev_found_reg <= 1'b0;
                            ag_found_reg <= 1'b0;
                            cur_rdy_reg  <= 1'b0;
                        end
                    end
                end
                S_CMD:
                begin
                    if (!slot_ok || head_reg == IW'(slot_reg))
                        state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    // head slot is observed, then ring rotates
                    if (head_reg == cur_reg)
                        cur_rdy_reg <= c_rdy[0];
                    if (c_rdy[0] && head_reg != '0
                        && (!ev_found_reg || cyc_dist < ev_dist_reg))
                    begin
                        ev_found_reg <= 1'b1;
                        ev_best_reg  <= head_reg;
                        ev_dist_reg  <= cyc_dist;
                        ev_prio_reg  <= c_prio[0];
                    end
                    // oldest wins, then higher priority, then lower slot
                    if (c_rdy[0] && (!ag_found_reg || h_age > ag_age_reg
                        || (h_age == ag_age_reg && (c_prio[0] > ag_prio_reg
                            || (c_prio[0] == ag_prio_reg && head_reg < ag_best_reg)))))
                    begin
                        ag_found_reg <= 1'b1;
                        ag_best_reg  <= head_reg;
                        ag_age_reg   <= h_age;
                        ag_prio_reg  <= c_prio[0];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (IW+1)'(NUM_SLOTS - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // scan began at head, so head is back at start now;
                    // wait here while the previous result is still held
                    if (done_go)
                    begin
                        state_reg <= to_win ? S_WIN : S_IDLE;
                        case (strat_reg)
                            mps_pkg::STRAT_RTC:
                            begin
                                if (cur_rdy_reg)
                                    out_reg <= 3'(cur_reg);
                                else
                                begin
                                    out_reg <= ev_found_reg ? 3'(ev_best_reg) : 3'd0;
                                    cur_reg <= ev_found_reg ? ev_best_reg : '0;
                                end
                            end
                            mps_pkg::STRAT_RR:
                            begin
                                if (slice_reg != '0)
                                begin
                                    slice_reg <= slice_reg - 1'b1;
                                    out_reg   <= 3'(cur_reg);
                                end
                                else if (ev_found_reg)
                                begin
                                    out_reg   <= 3'(ev_best_reg);
                                    cur_reg   <= ev_best_reg;
                                    slice_reg <= (ev_prio_reg != '0) ? ev_prio_reg - 1'b1 : '0;
                                end
                                else
                                begin
                                    // idle slot 0: fetch its priority at the head
                                    out_reg     <= 3'd0;
                                    cur_reg     <= '0;
                                    ag_best_reg <= '0;
                                end
                            end
                            mps_pkg::STRAT_AGING:
                            begin
                                if (ag_found_reg)
                                begin
                                    out_reg <= 3'(ag_best_reg);
                                    cur_reg <= ag_best_reg;
                                end
                                else
                                begin
                                    out_reg <= 3'd0;
                                    cur_reg <= '0;
                                end
                            end
                            default:
                            begin
                                out_reg <= ev_found_reg ? 3'(ev_best_reg) : 3'd0;
                                cur_reg <= ev_found_reg ? ev_best_reg : '0;
                            end
                        endcase
                    end
                end
                S_WIN:
                begin
                    // rotate the chosen slot to the head
                    if (win_hit)
                    begin
                        if (strat_reg == mps_pkg::STRAT_RR)
                            slice_reg <= (c_prio[0] != '0) ? c_prio[0] - 1'b1 : '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the multi-strategy process scheduler.
// Depends on mps_pkg and multi_strategy_process_scheduler; a scoreboard class
// predicts each schedule tick's slot and checks the block's answer in order.

class sched_scoreboard;
    logic [1:0]  strategy;
    logic        ready_flags [8];
    logic [7:0]  slot_prio [8];
    logic [15:0] slot_age [8];
    logic [2:0]  cur_slot;
    logic [7:0]  slice;
    logic [2:0]  pending_slots [$];
    int          errors;

    function new();
        strategy = mps_pkg::STRAT_EVEN;
        for (int k = 0; k < 8; k++)
        begin
            ready_flags[k] = 1'b0;
            slot_prio[k] = '0;
            slot_age[k] = '0;
        end
        cur_slot = '0;
        slice = '0;
        errors = 0;
    endfunction

    function void set_strategy(logic [1:0] s);
        strategy = s;
        if (s == mps_pkg::STRAT_RR)
            slice = slot_prio[cur_slot];
        else if (s == mps_pkg::STRAT_AGING)
            for (int k = 0; k < 8; k++)
                slot_age[k] = '0;
    endfunction

    // cyclic scan over slots 1..7 from the current slot
    function logic [2:0] next_ready_slot();
        int pos;
        pos = int'(cur_slot);
        for (int n = 0; n < 8; n++)
        begin
            pos = (pos + 1 < 8) ? pos + 1 : 1;
            if (ready_flags[pos])
                return pos[2:0];
        end
        return 3'd0;
    endfunction

    function logic [2:0] oldest_slot();
        int   best;
        bit   found;
        int   sum;
        best = 0;
        found = 0;
        for (int k = 0; k < 8; k++)
            if (ready_flags[k] && k != int'(cur_slot))
            begin
                sum = int'(slot_age[k]) + int'(slot_prio[k]);
                slot_age[k] = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
            end
        for (int k = 0; k < 8; k++)
        begin
            if (!ready_flags[k])
                continue;
            if (!found || slot_age[k] > slot_age[best] ||
                (slot_age[k] == slot_age[best] && slot_prio[k] > slot_prio[best]))
            begin
                best = k;
                found = 1;
            end
        end
        if (!found)
            return 3'd0;
        slot_age[best] = {8'd0, slot_prio[best]};
        return best[2:0];
    endfunction

    // note an accepted command; a tick queues its expected slot
    function void note_command(logic [1:0] c, logic [2:0] s, logic r, logic [7:0] p);
        logic [2:0] nxt;
        case (c)
            mps_pkg::CMD_START:
            begin
                ready_flags[s] = 1'b1;
                slot_prio[s] = p;
                slot_age[s] = '0;
            end
            mps_pkg::CMD_READY: ready_flags[s] = r;
            mps_pkg::CMD_TICK:
            begin
                case (strategy)
                    mps_pkg::STRAT_RTC:
                        nxt = ready_flags[cur_slot] ? cur_slot : next_ready_slot();
                    mps_pkg::STRAT_RR:
                        if (slice > 8'd0)
                        begin
                            slice = slice - 8'd1;
                            nxt = cur_slot;
                        end
                        else
                        begin
                            nxt = next_ready_slot();
                            slice = (slot_prio[nxt] > 8'd0) ? slot_prio[nxt] - 8'd1 : 8'd0;
                        end
                    mps_pkg::STRAT_AGING: nxt = oldest_slot();
                    default: nxt = next_ready_slot();
                endcase
                cur_slot = nxt;
                pending_slots.push_back(nxt);
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [2:0] got);
        logic [2:0] exp_slot;
        if (pending_slots.size() == 0)
        begin
            $error("unexpected transfer: next_process=%0d", got);
            errors++;
            return;
        end
        exp_slot = pending_slots.pop_front();
        if (got !== exp_slot)
        begin
            $error("next_process: expected %0d, actual %0d", exp_slot, got);
            errors++;
        end
    endfunction
endclass

module tb_top;
    // command code with no meaning to the block
    localparam logic [1:0] CmdUnused = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] cmd;
    logic [2:0] slot;
    logic       ready_req;
    logic [7:0] priority_req;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] next_process;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    sched_scoreboard sb;

    multi_strategy_process_scheduler u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .slot(slot), .ready_req(ready_req), .priority_req(priority_req),
        .out_valid(out_valid), .out_ready(out_ready), .next_process(next_process),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one command transfer, with a random lead-in gap; valid stays up on no gap
    task automatic send_cmd(logic [1:0] c, logic [2:0] s, logic r, logic [7:0] p);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        slot <= s;
        ready_req <= r;
        priority_req <= p;
        do @(posedge clk); while (!in_ready);
        sb.note_command(c, s, r, p);
        @(negedge clk);
    endtask

    // strategy write, only once every tick result is back and the block settled
    task automatic write_strategy(logic [1:0] s);
        in_valid <= 1'b0;
        while (sb.pending_slots.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= s;
        do @(posedge clk); while (!cfg_ready);
        sb.set_strategy(s);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random commands biased toward ticks, then set-ready and starts
    task automatic random_phase(int count);
        int roll;
        logic [7:0] prio;
        for (int i = 0; i < count; i++)
        begin
            roll = int'($urandom_range(0, 9));
            if (roll < 4)
                send_cmd(mps_pkg::CMD_TICK, 3'($urandom), 1'($urandom), 8'($urandom));
            else if (roll < 6)
            begin
                prio = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom);
                send_cmd(mps_pkg::CMD_START, 3'($urandom), 1'($urandom), prio);
            end
            else if (roll < 9)
                send_cmd(mps_pkg::CMD_READY, 3'($urandom), 1'($urandom), 8'($urandom));
            else
                send_cmd(CmdUnused, 3'($urandom), 1'($urandom), 8'($urandom));
        end
    endtask

    // result side: random stalls, sample at the rising edge
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(next_process);
            @(negedge clk);
        end
    end

    // stimulus and final verdict
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = mps_pkg::CMD_START;
        slot = '0;
        ready_req = 1'b0;
        priority_req = '0;
        cfg_valid = 1'b0;
        cfg_data = mps_pkg::STRAT_EVEN;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, every command and strategy
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_START, 3'd7, 1'b1, 8'd255);
        send_cmd(mps_pkg::CMD_START, 3'd0, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_START, 3'd3, 1'b0, 8'd1);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        send_cmd(CmdUnused, 3'd5, 1'b1, 8'd170);
        send_cmd(mps_pkg::CMD_READY, 3'd3, 1'b0, 8'd85);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        write_strategy(mps_pkg::STRAT_RTC);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_READY, 3'd7, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        write_strategy(mps_pkg::STRAT_RR);
        send_cmd(mps_pkg::CMD_START, 3'd2, 1'b1, 8'd2);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        write_strategy(mps_pkg::STRAT_AGING);
        send_cmd(mps_pkg::CMD_START, 3'd5, 1'b1, 8'd255);
        send_cmd(mps_pkg::CMD_START, 3'd6, 1'b1, 8'd255);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        send_cmd(mps_pkg::CMD_READY, 3'd0, 1'b1, 8'd0);
        send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);

        // random phases over every strategy, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            write_strategy(ph[1:0]);
            random_phase(ph[1:0] == mps_pkg::STRAT_AGING ? 180 : 100);
        end
        // long aging run to push ages toward saturation
        for (int k = 1; k < 8; k++)
            send_cmd(mps_pkg::CMD_START, k[2:0], 1'b1, 8'd255);
        for (int i = 0; i < 60; i++)
            send_cmd(mps_pkg::CMD_TICK, 3'd0, 1'b0, 8'd0);
        in_valid <= 1'b0;

        while (sb.pending_slots.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
